@@ rtl/core/vn2d_pkg.sv @@
package vn2d_pkg;

  // Field width of every vector and unit component on the ports
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;

  // Parameter defaults
  localparam int IN_WIDTH_DEF = 32;
  localparam int OUT_FRAC_DEF = 30;

  typedef enum logic [STATUS_W-1:0] {
    ST_NORM     = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  // Per-item control that rides alongside the arithmetic
  typedef struct packed {
    status_t             status;
    logic                sign_x;
    logic                sign_y;
    logic [DATA_W-1:0]   alt_x;
    logic [DATA_W-1:0]   alt_y;
  } ctl_t;

endpackage

@@ rtl/core/vn2d_front.sv @@
module vn2d_front #(
  parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_ok,
  input  logic [vn2d_pkg::DATA_W-1:0] vec_x,
  input  logic [vn2d_pkg::DATA_W-1:0] vec_y,
  input  logic [vn2d_pkg::DATA_W-1:0] fallback_x,
  input  logic [vn2d_pkg::DATA_W-1:0] fallback_y,
  output logic                        q_valid,
  input  logic                        q_pop,
  output vn2d_pkg::ctl_t              q_ctl,
  output logic [2*IN_WIDTH-1:0]       q_sq_x,
  output logic [2*IN_WIDTH-1:0]       q_sq_y
);
  import vn2d_pkg::*;

  localparam int MW = IN_WIDTH;
  localparam int PW = 2 * IN_WIDTH;

  logic [MW-1:0] raw_x, raw_y, mag_x, mag_y;
  logic [PW-1:0] sq_x, sq_y;
  ctl_t          ctl_in;
  logic          wr_en, rd_en, wr_idx;

  ctl_t          ent_ctl  [2];
  logic [PW-1:0] ent_sq_x [2];
  logic [PW-1:0] ent_sq_y [2];
  logic [1:0]    cnt;
  logic          head;

  // Classify: magnitudes, their squares, signs and the status of the item
  always_comb begin
    raw_x = vec_x[MW-1:0];
    raw_y = vec_y[MW-1:0];
    mag_x = raw_x[MW-1] ? (~raw_x + MW'(1)) : raw_x;
    mag_y = raw_y[MW-1] ? (~raw_y + MW'(1)) : raw_y;
    sq_x  = PW'(mag_x) * PW'(mag_x);
    sq_y  = PW'(mag_y) * PW'(mag_y);
    ctl_in.sign_x = raw_x[MW-1];
    ctl_in.sign_y = raw_y[MW-1];
    if (!in_ok) begin
      ctl_in.status = ST_INVALID;
      ctl_in.alt_x  = '0;
      ctl_in.alt_y  = '0;
    end else if (raw_x == '0 && raw_y == '0) begin
      ctl_in.status = ST_FALLBACK;
      ctl_in.alt_x  = fallback_x;
      ctl_in.alt_y  = fallback_y;
    end else begin
      ctl_in.status = ST_NORM;
      ctl_in.alt_x  = '0;
      ctl_in.alt_y  = '0;
    end
  end

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;
  assign wr_idx  = head ^ cnt[0];

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      head <= 1'b0;
    end else begin
      cnt  <= cnt + {1'b0, wr_en} - {1'b0, rd_en};
      head <= head ^ rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_ctl[wr_idx]  <= ctl_in;
      ent_sq_x[wr_idx] <= sq_x;
      ent_sq_y[wr_idx] <= sq_y;
    end
  end

  assign q_ctl  = ent_ctl[head];
  assign q_sq_x = ent_sq_x[head];
  assign q_sq_y = ent_sq_y[head];

endmodule

@@ rtl/core/vn2d_back.sv @@
module vn2d_back #(
  parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC = vn2d_pkg::OUT_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  vn2d_pkg::ctl_t              q_ctl,
  input  logic [2*IN_WIDTH-1:0]       q_sq_x,
  input  logic [2*IN_WIDTH-1:0]       q_sq_y,
  output logic                        empty,
  input  logic                        pop,
  output logic [vn2d_pkg::DATA_W-1:0] unit_x,
  output logic [vn2d_pkg::DATA_W-1:0] unit_y,
  output logic [vn2d_pkg::STATUS_W-1:0] status
);
  import vn2d_pkg::*;

  localparam int SW = 2 * IN_WIDTH;        // sum of squares
  localparam int RW = SW + 1;              // division remainder
  localparam int F  = OUT_FRAC;
  localparam int QW = 2 * OUT_FRAC + 1;    // quotient of the division
  localparam int L  = QW + F + 2;          // control pipeline length

  logic en;

  // Control pipeline, one entry per arithmetic stage
  logic c_vld [L];
  ctl_t c_ctl [L];

  // Division stages: index 0 is the sum stage
  logic [SW-1:0] s_p  [QW];
  logic [RW-1:0] r_x  [QW+1];
  logic [RW-1:0] r_y  [QW+1];
  logic [QW-1:0] d_x  [QW+1];
  logic [QW-1:0] d_y  [QW+1];

  // Square root stages: index 0 is the division result
  logic [QW-1:0] op_x  [F+2];
  logic [QW-1:0] op_y  [F+2];
  logic [QW:0]   res_x [F+2];
  logic [QW:0]   res_y [F+2];

  logic [SW-1:0] sum;

  assign q_pop = en && q_valid;

  // Advance the control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < L; t++) c_vld[t] <= 1'b0;
    end else if (en) begin
      c_vld[0] <= q_valid;
      for (int t = 1; t < L; t++) c_vld[t] <= c_vld[t-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctl[0] <= q_ctl;
      for (int t = 1; t < L; t++) c_ctl[t] <= c_ctl[t-1];
    end
  end

  // Sum of squares; a zero sum is forced to one so the divider stays defined
  assign sum = q_sq_x + q_sq_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s_p[0] <= (sum == '0) ? SW'(1) : sum;
      r_x[0] <= RW'(q_sq_x);
      r_y[0] <= RW'(q_sq_y);
      d_x[0] <= '0;
      d_y[0] <= '0;
    end
  end

  // Restoring division of square * 2^(2F) by the sum, one quotient bit a stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] rin_x, rin_y, s_ext;
    logic          ge_x, ge_y;

    if (k == 0) begin : g_first
      assign rin_x = r_x[k];
      assign rin_y = r_y[k];
    end else begin : g_rest
      assign rin_x = {r_x[k][RW-2:0], 1'b0};
      assign rin_y = {r_y[k][RW-2:0], 1'b0};
    end

    assign s_ext = {1'b0, s_p[k]};
    assign ge_x  = (rin_x >= s_ext);
    assign ge_y  = (rin_y >= s_ext);

    always_ff @(posedge clk) begin
      if (en) begin
        r_x[k+1] <= ge_x ? (rin_x - s_ext) : rin_x;
        r_y[k+1] <= ge_y ? (rin_y - s_ext) : rin_y;
        d_x[k+1] <= {d_x[k][QW-2:0], ge_x};
        d_y[k+1] <= {d_y[k][QW-2:0], ge_y};
      end
    end

    if (k < QW - 1) begin : g_sum
      always_ff @(posedge clk) begin
        if (en) s_p[k+1] <= s_p[k];
      end
    end
  end

  assign op_x[0]  = d_x[QW];
  assign op_y[0]  = d_y[QW];
  assign res_x[0] = '0;
  assign res_y[0] = '0;

  // Integer square root of the quotient, one root bit a stage
  for (genvar i = 0; i <= F; i++) begin : g_sqrt
    localparam logic [QW:0] ONE = (QW+1)'(1) << (2 * (F - i));
    logic [QW:0] t_x, t_y;
    logic        ge_x, ge_y;

    assign t_x  = res_x[i] + ONE;
    assign t_y  = res_y[i] + ONE;
    assign ge_x = ({1'b0, op_x[i]} >= t_x);
    assign ge_y = ({1'b0, op_y[i]} >= t_y);

    always_ff @(posedge clk) begin
      if (en) begin
        op_x[i+1]  <= ge_x ? QW'({1'b0, op_x[i]} - t_x) : op_x[i];
        op_y[i+1]  <= ge_y ? QW'({1'b0, op_y[i]} - t_y) : op_y[i];
        res_x[i+1] <= ge_x ? ((res_x[i] >> 1) + ONE) : (res_x[i] >> 1);
        res_y[i+1] <= ge_y ? ((res_y[i] >> 1) + ONE) : (res_y[i] >> 1);
      end
    end
  end

  // Form the result: apply signs or pass the alternate value
  logic [DATA_W-1:0] mag_ux, mag_uy, out_x, out_y;
  ctl_t              last;

  always_comb begin
    last   = c_ctl[L-1];
    mag_ux = {{(DATA_W-F-1){1'b0}}, res_x[F+1][F:0]};
    mag_uy = {{(DATA_W-F-1){1'b0}}, res_y[F+1][F:0]};
    if (last.status == ST_NORM) begin
      out_x = last.sign_x ? (DATA_W'(0) - mag_ux) : mag_ux;
      out_y = last.sign_y ? (DATA_W'(0) - mag_uy) : mag_uy;
    end else begin
      out_x = last.alt_x;
      out_y = last.alt_y;
    end
  end

  // Two-entry result queue; the pipeline holds only when it is full
  logic [DATA_W-1:0]   oq_x  [2];
  logic [DATA_W-1:0]   oq_y  [2];
  logic [STATUS_W-1:0] oq_st [2];
  logic [1:0]          oq_cnt;
  logic                oq_head, oq_wr, oq_rd, oq_idx;

  assign en     = !(c_vld[L-1] && oq_cnt == 2'd2);
  assign oq_wr  = en && c_vld[L-1];
  assign oq_rd  = pop && !empty;
  assign oq_idx = oq_head ^ oq_cnt[0];
  assign empty  = (oq_cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_cnt  <= 2'd0;
      oq_head <= 1'b0;
    end else begin
      oq_cnt  <= oq_cnt + {1'b0, oq_wr} - {1'b0, oq_rd};
      oq_head <= oq_head ^ oq_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_x[oq_idx]  <= out_x;
      oq_y[oq_idx]  <= out_y;
      oq_st[oq_idx] <= last.status;
    end
  end

  assign unit_x = oq_x[oq_head];
  assign unit_y = oq_y[oq_head];
  assign status = oq_st[oq_head];

endmodule

@@ rtl/core/vector_normalize_2d_core.sv @@
// Normalizes a 2D vector to a unit vector in signed Q2.OUT_FRAC, rounded toward
// zero, with a fallback vector passed through for a zero input and a zeroed,
// flagged result for an invalid one. One item is accepted per cycle while full
// is low, and the pipeline is fully overlapped; the path from push to the output
// runs through the bit-per-stage divider (2*OUT_FRAC+1 stages) followed by the
// bit-per-stage square root (OUT_FRAC+1 stages). Both internal queues hold two
// entries; when the output is not popped the pipeline holds and full rises.
module vector_normalize_2d_core #(
  parameter int IN_WIDTH = vn2d_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC = vn2d_pkg::OUT_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_ok,
  input  logic [vn2d_pkg::DATA_W-1:0]   vec_x,
  input  logic [vn2d_pkg::DATA_W-1:0]   vec_y,
  input  logic [vn2d_pkg::DATA_W-1:0]   fallback_x,
  input  logic [vn2d_pkg::DATA_W-1:0]   fallback_y,
  output logic                          empty,
  input  logic                          pop,
  output logic [vn2d_pkg::DATA_W-1:0]   unit_x,
  output logic [vn2d_pkg::DATA_W-1:0]   unit_y,
  output logic [vn2d_pkg::STATUS_W-1:0] status
);
  import vn2d_pkg::*;

  logic                  q_valid, q_pop;
  ctl_t                  q_ctl;
  logic [2*IN_WIDTH-1:0] q_sq_x, q_sq_y;

  vn2d_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk, .rst, .push, .full, .in_ok, .vec_x, .vec_y, .fallback_x, .fallback_y,
    .q_valid, .q_pop, .q_ctl, .q_sq_x, .q_sq_y
  );

  vn2d_back #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC(OUT_FRAC)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_ctl, .q_sq_x, .q_sq_y,
    .empty, .pop, .unit_x, .unit_y, .status
  );

endmodule

@@ rtl/core/vn2d_checker.sv @@
module vn2d_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [vn2d_pkg::DATA_W-1:0]   unit_x,
  input logic [vn2d_pkg::DATA_W-1:0]   unit_y,
  input logic [vn2d_pkg::STATUS_W-1:0] status
);
  import vn2d_pkg::*;

  // Nothing is waiting and nothing is held off right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result shown or input blocked after reset");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_NORM || status == ST_FALLBACK || status == ST_INVALID))
    else $error("undefined status code");

  // An invalid item carries zero components
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_INVALID) |-> (unit_x == '0 && unit_y == '0))
    else $error("invalid result with nonzero components");

  // A normalized component never exceeds one
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_NORM) |->
      ($signed(unit_x) <= $signed(32'h4000_0000) && $signed(unit_x) >= $signed(32'hC000_0000)
       && $signed(unit_y) <= $signed(32'h4000_0000)
       && $signed(unit_y) >= $signed(32'hC000_0000)))
    else $error("normalized component out of range");

  // A waiting result holds until its transfer
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(unit_x) && $stable(unit_y) && $stable(status)))
    else $error("waiting result changed before transfer");

endmodule

bind vector_normalize_2d_core vn2d_checker u_vn2d_checker (
  .clk, .rst, .full, .empty, .pop, .unit_x, .unit_y, .status
);

@@ bench/vector_normalize_2d_core_tb.sv @@
`timescale 1ns / 1ps

module vector_normalize_2d_core_tb;
  import vn2d_pkg::*;

  localparam int OUT_FRAC = OUT_FRAC_DEF;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [DATA_W-1:0]   ux;
    logic [DATA_W-1:0]   uy;
    logic [STATUS_W-1:0] st;
  } unit_res_t;

  // Expected unit vectors, computed at accept time and checked in order
  class unit_scoreboard;
    unit_res_t pending[$];
    int        errors = 0;

    // floor(mag * 2^OUT_FRAC / sqrt(sum)) by bit-serial search
    function logic [63:0] ratio(logic [63:0] mag, logic [63:0] sum);
      logic [127:0] goal;
      logic [127:0] prod;
      logic [63:0]  q;
      logic [63:0]  t;
      goal = ({64'd0, mag * mag}) << (2 * OUT_FRAC);
      q = '0;
      for (int b = OUT_FRAC; b >= 0; b--) begin
        t = q | (64'd1 << b);
        prod = {64'd0, t * t} * {64'd0, sum};
        if (prod <= goal) q = t;
      end
      return q;
    endfunction

    function void note(logic ok, logic [31:0] vx, logic [31:0] vy,
                       logic [31:0] fx, logic [31:0] fy);
      unit_res_t   r;
      logic [63:0] mx, my, sum, qx, qy;
      if (!ok) begin
        r.ux = '0; r.uy = '0; r.st = ST_INVALID;
      end else begin
        mx = vx[31] ? 64'(-$signed({1'b1, vx})) : 64'(vx);
        my = vy[31] ? 64'(-$signed({1'b1, vy})) : 64'(vy);
        sum = mx * mx + my * my;
        if (sum == 0) begin
          r.ux = fx; r.uy = fy; r.st = ST_FALLBACK;
        end else begin
          qx = ratio(mx, sum);
          qy = ratio(my, sum);
          r.ux = vx[31] ? 32'(-qx) : 32'(qx);
          r.uy = vy[31] ? 32'(-qy) : 32'(qy);
          r.st = ST_NORM;
        end
      end
      pending.push_back(r);
    endfunction

    function void check(logic [31:0] ux, logic [31:0] uy, logic [1:0] st);
      unit_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result ux=%h uy=%h status=%0d", ux, uy, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ux !== e.ux) begin
        $error("unit_x expected %h actual %h", e.ux, ux); errors++;
      end
      if (uy !== e.uy) begin
        $error("unit_y expected %h actual %h", e.uy, uy); errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st); errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, full, in_ok, empty, pop;
  logic [DATA_W-1:0] vec_x, vec_y, fallback_x, fallback_y, unit_x, unit_y;
  logic [STATUS_W-1:0] status;
  bit   calm = 0;
  int   stall_cnt = 0;
  unit_scoreboard sb = new();

  vector_normalize_2d_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Note transfers on both sides
  always @(posedge clk) begin
    if (!rst && push && !full) sb.note(in_ok, vec_x, vec_y, fallback_x, fallback_y);
    if (!rst && pop && !empty) sb.check(unit_x, unit_y, status);
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drain side: random pop stalls
  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      pop <= calm || ($urandom_range(99) >= 32);
    end
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // Offer one item, hold it until transfer; push stays high for the next one
  task automatic send(logic ok, logic [31:0] vx, logic [31:0] vy,
                      logic [31:0] fx, logic [31:0] fy);
    @(negedge clk);
    while (idle_now()) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1; in_ok <= ok; vec_x <= vx; vec_y <= vy;
    fallback_x <= fx; fallback_y <= fy;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push, then wait for every expected result
  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(255)) - 128);
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4: return 32'd0;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    logic [31:0] a, b;
    rst = 1; push = 0; in_ok = 0;
    vec_x = '0; vec_y = '0; fallback_x = '0; fallback_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed corners: invalid, zero vector, axes, extremes
    send(0, 32'h0001_0000, 32'h0, 32'h4000_0000, 32'h0);
    send(0, 32'h0, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
    send(1, 32'h0, 32'h0, 32'h4000_0000, 32'h0);
    send(1, 32'h0, 32'h0, 32'hc000_0000, 32'hffff_ffff);
    send(1, 32'h0, 32'h0, 32'h5555_aaaa, 32'haaaa_5555);
    send(1, 32'h0001_0000, 32'h0, 0, 0);
    send(1, 32'h0, 32'hffff_0000, 0, 0);
    send(1, 32'h8000_0000, 32'h0, 0, 0);
    send(1, 32'h0, 32'h7fff_ffff, 0, 0);
    send(1, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send(1, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send(1, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send(1, 32'h1, 32'h1, 0, 0);
    send(1, 32'hffff_ffff, 32'h1, 0, 0);
    send(1, 32'h1, 32'h8000_0000, 0, 0);
    send(1, 32'h0003_0000, 32'h0004_0000, 0, 0);
    send(1, 32'hfffd_0000, 32'hfffc_0000, 0, 0);
    send(1, 32'h1, 32'h0, 0, 0);

    // Hold off the sender until the pipe is empty
    drain();

    // Random part, with one stretch of full throughput
    for (int i = 0; i < 1450; i++) begin
      calm = (i >= 500 && i < 700);
      a = rand_comp();
      b = rand_comp();
      send($urandom_range(15) != 0, a, b, $urandom(), $urandom());
    end
    calm = 0;

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
